[design/log_tone_map_pixel_top_defines.svh]
// Assertion macros shared by the log tone map RTL.
`ifndef LOG_TONE_MAP_PIXEL_TOP_DEFINES_SVH
`define LOG_TONE_MAP_PIXEL_TOP_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define LGTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger at one edge implies a condition at the next edge.
`define LGTM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/lgtm_pkg.sv]
// Package for the log tone map block: widths, types, divider states and the log ROM.
package lgtm_pkg;

  // Fraction bits of the log table entries
  localparam int FRAC_BITS = 24;
  // Working precision of the series that builds the table
  localparam int WORK_BITS = 54;
  // Quotient bits; also the scale shift, since 255*x = (x << 8) - x
  localparam int QUOT_W    = 8;
  localparam int STEP_W    = $clog2(QUOT_W);
  // Dividend width: a table entry scaled by 255
  localparam int NUM_W     = FRAC_BITS + QUOT_W;
  localparam int ROM_DEPTH = 256;

  typedef logic [FRAC_BITS-1:0] log_t;
  typedef logic [NUM_W-1:0]     num_t;
  typedef logic [QUOT_W-1:0]    quot_t;
  typedef logic [ROM_DEPTH-1:0][FRAC_BITS-1:0] log_rom_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SETUP,
    DIV_STEP
  } div_state_e;

  // Divider status seen by the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Shift-subtract division, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + v/255) = 2*atanh(v/(510+v)), summed as an odd power series
  function automatic log_t log_value(input logic [7:0] v);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] k;
    logic [63:0] full;
    a = 64'(v);
    b = 64'd510 + a;
    t = udiv64(a << WORK_BITS, b);
    s = '0;
    k = 64'd1;
    while (t != '0) begin
      s = s + udiv64(t, k);
      t = udiv64(t * a, b);
      t = udiv64(t * a, b);
      k = k + 64'd2;
    end
    full = (s << 1) >> (WORK_BITS - FRAC_BITS);
    return full[FRAC_BITS-1:0];
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    for (int v = 0; v < ROM_DEPTH; v++) begin
      rom[v] = log_value(8'(v));
    end
    return rom;
  endfunction

  // Monotone table, entry 0 is zero
  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

[design/lgtm_div.sv]
// Restoring divider for the map pass: scales the dividend by 255, then one quotient bit a cycle.
`include "log_tone_map_pixel_top_defines.svh"

module lgtm_div
  import lgtm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  log_t        num_i,
  input  log_t        den_i,
  output div_status_t status_o,
  output quot_t       quot_o
);

  div_state_e        state_q, state_d;
  num_t              rem_q, rem_d;
  num_t              dvs_q, dvs_d;
  quot_t             quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;

  num_t              op_a;
  num_t              op_b;
  logic [NUM_W:0]    diff;
  logic              borrow;
  logic              last_step;

  // Shared subtractor: computes 256*x - x in setup, trial subtraction in each step
  assign op_a   = (state_q == DIV_SETUP) ? {rem_q[FRAC_BITS-1:0], {QUOT_W{1'b0}}} : rem_q;
  assign op_b   = (state_q == DIV_SETUP) ? rem_q : dvs_q;
  assign diff   = {1'b0, op_a} - {1'b0, op_b};
  assign borrow = diff[NUM_W];

  assign last_step = (step_q == STEP_W'(QUOT_W - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) state_d = DIV_SETUP;
      end
      DIV_SETUP: begin
        state_d = DIV_STEP;
      end
      DIV_STEP: begin
        if (last_step) state_d = DIV_IDLE;
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  // Datapath controls
  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    step_d = step_q;
    done_d = 1'b0;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          rem_d = num_t'(num_i);
          dvs_d = num_t'(den_i);
        end
      end
      DIV_SETUP: begin
        // Dividend is 255*T[p]; divisor is aligned to the top quotient bit
        rem_d  = diff[NUM_W-1:0];
        dvs_d  = dvs_q << (QUOT_W - 1);
        quot_d = '0;
        step_d = '0;
      end
      DIV_STEP: begin
        // T[p] <= T[max] keeps the quotient within 8 bits; T[max] is nonzero here
        if (!borrow) rem_d = diff[NUM_W-1:0];
        quot_d = {quot_q[QUOT_W-2:0], !borrow};
        dvs_d  = dvs_q >> 1;
        step_d = step_q + 1'b1;
        done_d = last_step;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = (state_q != DIV_IDLE);
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

  `LGTM_ASSERT(a_start_when_idle, !start_i || (state_q == DIV_IDLE && !done_q), "divider started while busy")
  `LGTM_ASSERT_NEXT(a_setup_then_step, state_q == DIV_SETUP, state_q == DIV_STEP && step_q == '0, "setup did not enter first step")
  `LGTM_ASSERT_NEXT(a_done_after_last, state_q == DIV_STEP && last_step, done_q && state_q == DIV_IDLE, "last step did not finish")

endmodule

[design/log_tone_map_pixel_top.sv]
// Top level of the log tone map block: running maximum, special cases and output register.
//
//   channel | handshake                  | payload
//   --------+----------------------------+--------------------------------
//   in      | in_valid_i / in_stall_o    | cmd_i, pixel_i, frame_start_i
//   out     | out_valid_o / out_stall_i  | mapped_o
//
// A scan pixel may update the running maximum and gives no result.
// A map pixel with a zero maximum or above the maximum gives its result in the output
// register in the cycle after acceptance, and the next request can follow at once.
// Any other map pixel reads the log table on acceptance, then scales by 255 and forms the
// eight quotient bits, all on the divider's one shared subtractor, then hands over the result.
// Reset clears the running maximum and all control state; no table clearing is needed.
// While a result waits under out_stall_i, a new request is held off.
`include "log_tone_map_pixel_top_defines.svh"

module log_tone_map_pixel_top
  import lgtm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] pixel_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] mapped_o
);

  logic [7:0]  running_max_q, running_max_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  mapped_q, mapped_d;

  logic        in_accept;
  logic        max_zero;
  logic        above_max;
  logic        div_start;
  div_status_t div_stat;
  quot_t       div_quot;

  // Hold off requests while dividing, while handing over, or while the output is blocked
  assign in_stall_o = div_stat.busy || div_stat.done || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign max_zero  = (running_max_q == '0);
  assign above_max = (pixel_i > running_max_q);
  assign div_start = in_accept && cmd_i && !max_zero && !above_max;

  lgtm_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (LOG_ROM[pixel_i]),
    .den_i    (LOG_ROM[running_max_q]),
    .status_o (div_stat),
    .quot_o   (div_quot)
  );

  // Running maximum over scan pixels, restarted on frame start
  always_comb begin
    running_max_d = running_max_q;
    if (in_accept && !cmd_i && (frame_start_i || above_max)) running_max_d = pixel_i;
  end

  // Output register: special cases load on acceptance, others when the divider finishes
  always_comb begin
    out_valid_d = out_valid_q;
    mapped_d    = mapped_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (in_accept && cmd_i && max_zero) begin
      out_valid_d = 1'b1;
      mapped_d    = '0;
    end else if (in_accept && cmd_i && above_max) begin
      out_valid_d = 1'b1;
      mapped_d    = '1;
    end else if (div_stat.done) begin
      out_valid_d = 1'b1;
      mapped_d    = div_quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_max_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      running_max_q <= running_max_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mapped_q <= mapped_d;
  end

  assign out_valid_o = out_valid_q;
  assign mapped_o    = mapped_q;

  `LGTM_ASSERT(a_done_slot_free, !div_stat.done || !out_valid_q, "quotient arrived with output full")
  `LGTM_ASSERT_NEXT(a_zero_max_result, in_accept && cmd_i && max_zero, out_valid_q && mapped_q == '0, "zero maximum did not give zero")
  `LGTM_ASSERT_NEXT(a_max_update, in_accept && !cmd_i && (frame_start_i || above_max), running_max_q == $past(pixel_i), "running maximum not updated")

endmodule
